@@ hw/rtl/polyline_corridor_hit_test_macros.svh @@
// assertion macros shared by the corridor hit test checkers
// no dependencies; included by the checker file
`ifndef POLYLINE_CORRIDOR_HIT_TEST_MACROS_SVH
`define POLYLINE_CORRIDOR_HIT_TEST_MACROS_SVH
// same-cycle implication, disabled while in reset
`define PCH_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while in reset
`define PCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/pch_pkg.sv @@
// shared types and constants of the corridor hit test
// no dependencies; used by every other file of the block but pch_ram and the macro header
`default_nettype none
package pch_pkg;
	localparam int MAX_WAYPOINTS_DEF = 64;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int RAD_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int T_FRAC = 16;
	localparam int DEGEN_MAX = 6;
	localparam int LIMIT_SHIFT = 32;
	localparam int LIM_W = 2 * RAD_W + LIMIT_SHIFT;
	localparam logic [RAD_W-1:0] RESET_RADIUS = 16'd1280;

	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 8'd1;

	typedef enum logic {REQ_WRITE = 1'b0, REQ_QUERY = 1'b1} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_CAP, ST_GO, ST_SEG, ST_NEXT, ST_DONE
	} walk_state_t;

	typedef enum logic [2:0] {
		SG_IDLE, SG_DOT, SG_DECIDE, SG_DIV, SG_TMUL, SG_DMAG, SG_SQ, SG_CMP
	} seg_state_t;

	typedef struct packed {
		logic             start;
		logic [LIM_W-1:0] limit;
	} seg_ctl_t;

	typedef struct packed {
		logic done;
		logic hit;
	} seg_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/pch_req_if.sv @@
// request channel: waypoint writes and query points
// depends on pch_pkg
`default_nettype none
interface pch_req_if import pch_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int IDX_W = 6
);
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [IDX_W-1:0]       wp_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic                   no_stop;
	modport source (output valid, req_type, wp_index, coord_x, coord_y, coord_z, no_stop,
		input ready);
	modport sink (input valid, req_type, wp_index, coord_x, coord_y, coord_z, no_stop,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pch_rsp_if.sv @@
// result channel: one in_zone beat per query
// depends on pch_pkg
`default_nettype none
interface pch_rsp_if import pch_pkg::*;;
	logic valid;
	logic ready;
	logic in_zone;
	modport source (output valid, in_zone, input ready);
	modport sink (input valid, in_zone, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pch_cfg_if.sv @@
// configuration write channel: register index and data
// depends on pch_pkg
`default_nettype none
interface pch_cfg_if import pch_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pch_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module pch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/pch_seg.sv @@
// one segment distance unit: squared distance from a point to segment a..b
// shared multiplier steps, restoring divider for t; depends on pch_pkg
`default_nettype none
module pch_seg import pch_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire seg_ctl_t                   ctl,
	input  wire logic [3*COORD_WIDTH-1:0]   a_pt,
	input  wire logic [3*COORD_WIDTH-1:0]   b_pt,
	input  wire logic [3*COORD_WIDTH-1:0]   p_pt,
	output seg_sts_t                        sts
);
	localparam int AW = COORD_WIDTH + 1;
	localparam int PW = 2 * AW;
	localparam int DW = PW + 2;
	localparam int TW = T_FRAC + 1;
	localparam int TPW = AW + TW + 1;
	localparam int MW = TPW;
	localparam int HW = (MW + 1) / 2;
	localparam int SW = 2 * MW + 2;
	localparam int CMPW = (SW > LIM_W) ? SW : LIM_W;
	localparam int CNT_W = $clog2(T_FRAC);

	seg_state_t state_q, state_d;
	logic signed [AW-1:0] ab_q [3];
	logic signed [AW-1:0] ap_q [3];
	logic [2:0]           step_q;
	logic [1:0]           axis_q;
	logic [DW-1:0]        denom_q;
	logic signed [DW-1:0] dot_q;
	logic signed [PW-1:0] prod_q;
	logic [DW:0]          rem_q;
	logic [T_FRAC-1:0]    quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TW-1:0]        t_q;
	logic signed [TPW-1:0] tprod_q;
	logic [MW-1:0]        dmag_q;
	logic [2*HW-1:0]      sqp_q;
	logic [SW-1:0]        acc_q;
	logic                 done_q, hit_q;

	logic [1:0]           dax;
	logic signed [AW-1:0] mul_l, mul_r;
	logic signed [PW-1:0] mul_p;
	logic [DW:0]          rem_sh, rem_nx;
	logic                 rem_ge;
	logic                 degen, dot_pos, dot_ge;
	logic signed [TW:0]   t_s;
	logic signed [TPW-1:0] tprod_d;
	logic signed [TPW:0]  ap_ext, d_val, d_neg;
	logic [MW-1:0]        dmag_d;
	logic [HW-1:0]        dl, dh, sq_a, sq_b;
	logic [2*HW-1:0]      sqp_d;
	logic [SW-1:0]        sq_add;
	logic                 near;

	// shared multiplier for denom and dot terms
	always_comb begin
		dax = (step_q < 3'd3) ? step_q[1:0] : 2'(step_q - 3'd3);
		mul_l = (step_q < 3'd3) ? ab_q[dax] : ap_q[dax];
		mul_r = ab_q[dax];
		mul_p = mul_l * mul_r;
	end

	always_comb begin
		rem_sh = {rem_q[DW-1:0], 1'b0};
		rem_ge = rem_sh >= {1'b0, denom_q};
		rem_nx = rem_ge ? (rem_sh - {1'b0, denom_q}) : rem_sh;
		degen = denom_q <= DW'(DEGEN_MAX);
		dot_pos = dot_q > 0;
		dot_ge = $unsigned(dot_q) >= denom_q;
	end

	always_comb begin
		t_s = $signed({1'b0, t_q});
		tprod_d = ab_q[axis_q] * t_s;
		ap_ext = {{(TPW + 1 - AW - T_FRAC){ap_q[axis_q][AW-1]}}, ap_q[axis_q],
			{T_FRAC{1'b0}}};
		d_val = ap_ext - {tprod_q[TPW-1], tprod_q};
		d_neg = -d_val;
		dmag_d = d_val[TPW] ? d_neg[MW-1:0] : d_val[MW-1:0];
	end

	// split square: low*low, 2*high*low, high*high
	always_comb begin
		dl = dmag_q[HW-1:0];
		dh = {{(2 * HW - MW){1'b0}}, dmag_q[MW-1:HW]};
		sq_a = (step_q == 3'd0) ? dl : dh;
		sq_b = (step_q == 3'd2) ? dh : dl;
		sqp_d = sq_a * sq_b;
		case (step_q)
			3'd1:    sq_add = SW'(sqp_q);
			3'd2:    sq_add = SW'(sqp_q) << (HW + 1);
			3'd3:    sq_add = SW'(sqp_q) << (2 * HW);
			default: sq_add = '0;
		endcase
		near = CMPW'(acc_q) <= CMPW'(ctl.limit);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SG_IDLE:   if (ctl.start) state_d = SG_DOT;
			SG_DOT:    if (step_q == 3'd6) state_d = SG_DECIDE;
			SG_DECIDE: state_d = (!degen && dot_pos && !dot_ge) ? SG_DIV : SG_TMUL;
			SG_DIV:    if (cnt_q == CNT_W'(T_FRAC - 1)) state_d = SG_TMUL;
			SG_TMUL:   state_d = SG_DMAG;
			SG_DMAG:   state_d = SG_SQ;
			SG_SQ: begin
				if (step_q == 3'd3) state_d = (axis_q == 2'd2) ? SG_CMP : SG_TMUL;
			end
			SG_CMP:    state_d = SG_IDLE;
			default:   state_d = SG_IDLE;
		endcase
	end

	always_comb begin
		sts.done = done_q;
		sts.hit = hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SG_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == SG_CMP);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SG_IDLE: begin
				if (ctl.start) begin
					for (int k = 0; k < 3; k++) begin
						ab_q[k] <= AW'($signed(b_pt[k*COORD_WIDTH +: COORD_WIDTH]))
							- AW'($signed(a_pt[k*COORD_WIDTH +: COORD_WIDTH]));
						ap_q[k] <= AW'($signed(p_pt[k*COORD_WIDTH +: COORD_WIDTH]))
							- AW'($signed(a_pt[k*COORD_WIDTH +: COORD_WIDTH]));
					end
					denom_q <= '0;
					dot_q <= '0;
					acc_q <= '0;
					step_q <= '0;
					axis_q <= '0;
				end
			end
			SG_DOT: begin
				prod_q <= mul_p;
				if (step_q >= 3'd1 && step_q <= 3'd3) begin
					denom_q <= denom_q + {2'b00, prod_q};
				end else if (step_q >= 3'd4) begin
					dot_q <= dot_q + DW'(prod_q);
				end
				step_q <= (step_q == 3'd6) ? 3'd0 : step_q + 3'd1;
			end
			SG_DECIDE: begin
				t_q <= (!degen && dot_pos) ? (TW'(1) << T_FRAC) : '0;
				rem_q <= {1'b0, dot_q};
				quo_q <= '0;
				cnt_q <= '0;
			end
			SG_DIV: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[T_FRAC-2:0], rem_ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(T_FRAC - 1)) begin
					t_q <= {1'b0, quo_q[T_FRAC-2:0], rem_ge};
				end
			end
			SG_TMUL: tprod_q <= tprod_d;
			SG_DMAG: begin
				dmag_q <= dmag_d;
				step_q <= '0;
			end
			SG_SQ: begin
				sqp_q <= sqp_d;
				acc_q <= acc_q + sq_add;
				if (step_q == 3'd3) begin
					step_q <= '0;
					axis_q <= axis_q + 2'd1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
			SG_CMP: hit_q <= near;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/polyline_corridor_hit_test.sv @@
// corridor hit test top level: route ram, segment walker, result register
// depends on pch_pkg, the channel interfaces, pch_ram and pch_seg
//
// req channel: req_type write stores (x, y, z, no_stop) at wp_index and gives no
// result; query walks segments i..i+1 with i+1 < route_len (clamped to
// MAX_WAYPOINTS) whose start waypoint is flagged and returns one rsp beat with in_zone.
// cfg channel: index 0 route_len, index 1 corridor_radius (Q16.0); always ready,
// other indexes are ignored. write only while no query is in flight.
// a query reads the route waypoint by waypoint; each flagged segment takes 6
// dot/denom multiplies, 16 divider steps (only when 0 < t < 1), three
// axes of t multiply, magnitude and 3-part square; the walk stops at the first hit.
// pch_seg shares one multiplier for the dot/denom terms and has a bit-per-cycle divider.
// one query is in flight at a time; req.ready is low while it runs.
// the result waits in an output register and the walker goes back to idle;
// a stalled rsp only holds a second finished query at its last step, with
// req.ready low, until the register frees.
// reset clears route_len to 0 and the radius to 1280; the route ram is not
// cleared, its entries hold nothing meaningful until written.
`default_nettype none
module polyline_corridor_hit_test import pch_pkg::*; #(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pch_cfg_if.sink   cfg,
	pch_req_if.sink   req,
	pch_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int LEN_W = $clog2(MAX_WAYPOINTS + 1);
	localparam int WORD_W = 3 * COORD_WIDTH + 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WAYPOINTS);

	walk_state_t state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_eff;
	logic [RAD_W-1:0]  radius_q;
	logic [3*COORD_WIDTH-1:0] p_q;
	logic [LIM_W-1:0]  limit_q;
	logic [WORD_W-1:0] a_q, b_q, rdata;
	logic [IDX_W-1:0]  rd_addr_q;
	logic              first_q, hit_q;
	logic              rsp_valid_q, in_zone_q;
	logic              req_acc, query_acc, wr_en, rsp_load;
	seg_ctl_t          seg_ctl;
	seg_sts_t          seg_sts;

	assign len_eff = (len_q > MAX_LEN) ? MAX_LEN : len_q;
	assign req_acc = req.valid && req.ready;
	assign query_acc = req_acc && (req.req_type == REQ_QUERY);
	assign wr_en = req_acc && (req.req_type == REQ_WRITE)
		&& ({1'b0, req.wp_index} < (IDX_W + 1)'(MAX_WAYPOINTS));
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	pch_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WAYPOINTS)) u_route (
		.clk  (clk),
		.we   (wr_en),
		.waddr(req.wp_index),
		.wdata({req.no_stop, req.coord_z, req.coord_y, req.coord_x}),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign seg_ctl.start = (state_q == ST_GO);
	assign seg_ctl.limit = limit_q;

	pch_seg #(.COORD_WIDTH(COORD_WIDTH)) u_seg (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (seg_ctl),
		.a_pt  (a_q[3*COORD_WIDTH-1:0]),
		.b_pt  (b_q[3*COORD_WIDTH-1:0]),
		.p_pt  (p_q),
		.sts   (seg_sts)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) state_d = (len_eff < LEN_W'(2)) ? ST_DONE : ST_RD;
			end
			ST_RD:  state_d = ST_CAP;
			ST_CAP: begin
				if (first_q) state_d = ST_RD;
				else state_d = a_q[WORD_W-1] ? ST_GO : ST_NEXT;
			end
			ST_GO:  state_d = ST_SEG;
			ST_SEG: begin
				if (seg_sts.done) state_d = seg_sts.hit ? ST_DONE : ST_NEXT;
			end
			ST_NEXT: begin
				state_d = ((LEN_W'(rd_addr_q) + LEN_W'(1)) < len_eff) ? ST_RD : ST_DONE;
			end
			ST_DONE: if (rsp_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		rsp.valid = rsp_valid_q;
		rsp.in_zone = in_zone_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			radius_q <= RESET_RADIUS;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ROUTE_LEN: len_q <= cfg.data[LEN_W-1:0];
					CFG_RADIUS:    radius_q <= cfg.data[RAD_W-1:0];
					default: ;
				endcase
			end
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			p_q <= {req.coord_z, req.coord_y, req.coord_x};
			limit_q <= {(2 * RAD_W)'(radius_q) * (2 * RAD_W)'(radius_q),
				{LIMIT_SHIFT{1'b0}}};
			rd_addr_q <= '0;
			first_q <= 1'b1;
			hit_q <= 1'b0;
		end
		case (state_q)
			ST_CAP: begin
				if (first_q) begin
					a_q <= rdata;
					first_q <= 1'b0;
					rd_addr_q <= rd_addr_q + 1'b1;
				end else begin
					b_q <= rdata;
				end
			end
			ST_SEG: if (seg_sts.done && seg_sts.hit) hit_q <= 1'b1;
			ST_NEXT: begin
				a_q <= b_q;
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			default: ;
		endcase
		if (rsp_load) in_zone_q <= hit_q;
	end
endmodule
`default_nettype wire

@@ hw/rtl/pch_chk.sv @@
// port-level checker for the corridor hit test, bound to the top level
// depends on pch_pkg and polyline_corridor_hit_test_macros.svh
`default_nettype none
`include "polyline_corridor_hit_test_macros.svh"
module pch_chk import pch_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic req_type,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic in_zone
);
	`PCH_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")
	`PCH_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(in_zone), "result changed while stalled")
	`PCH_ASSERT_NEXT(a_query_busy, clk, arst_n, req_valid && req_ready && req_type == REQ_QUERY, !req_ready, "new beat taken during a query")
	`PCH_ASSERT_SAME(a_rsp_source, clk, arst_n, $rose(rsp_valid), $past(!req_ready), "result without a query in flight")
endmodule

bind polyline_corridor_hit_test pch_chk u_pch_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_type (req.req_type),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.in_zone  (rsp.in_zone)
);
`default_nettype wire
